[rtl/lidar_scan_packet_decoder_assert.svh]
// assertion macros for the lidar scan packet decoder
// expects clk_i and rst_ni in the module that uses them
`ifndef LIDAR_SCAN_PACKET_DECODER_ASSERT_SVH
`define LIDAR_SCAN_PACKET_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define LSPD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lspd assertion failed");
`define LSPD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("lspd assertion failed");
`else
`define LSPD_ASSERT(label, prop)
`define LSPD_ASSERT_ALWAYS(label, prop)
`endif
`endif

[rtl/lspd_pkg.sv]
// shared constants, command/status types and the arctangent table
// used by lspd_ctrl, lspd_datapath and the top level
package lspd_pkg;

  localparam logic [7:0] SyncByte0 = 8'hAA;
  localparam logic [7:0] SyncByte1 = 8'h55;

  localparam int unsigned CordicSteps = 17;
  localparam int unsigned FullTurn64  = 23040;
  localparam int unsigned FullTurnU   = 5898240;
  localparam int unsigned RoundHalf   = 128;
  localparam int unsigned XGain       = 15530;
  localparam int unsigned YBase       = 1354216;
  localparam int unsigned YSlope      = 2180;
  localparam int unsigned DivSteps    = 32;

  typedef struct packed {
    logic ld_kind;
    logic ld_count;
    logic ld_lo;
    logic ld_first;
    logic ld_span;
    logic clr_ctr;
    logic start;
    logic mod_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic calc_done;
    logic mod_done;
    logic out_free;
    logic last;
  } stat_t;

  // atan(2^-i) in units of 2^-14 degree
  function automatic logic [21:0] atan_lut(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:    v = 22'd737280;
      5'd1:    v = 22'd435242;
      5'd2:    v = 22'd229970;
      5'd3:    v = 22'd116736;
      5'd4:    v = 22'd58595;
      5'd5:    v = 22'd29326;
      5'd6:    v = 22'd14667;
      5'd7:    v = 22'd7334;
      5'd8:    v = 22'd3667;
      5'd9:    v = 22'd1833;
      5'd10:   v = 22'd917;
      5'd11:   v = 22'd458;
      5'd12:   v = 22'd229;
      5'd13:   v = 22'd115;
      5'd14:   v = 22'd57;
      5'd15:   v = 22'd29;
      5'd16:   v = 22'd14;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/lspd_ctrl.sv]
// parse and sequencing state machine of the lidar scan packet decoder
// depends on lspd_pkg; drives the datapath by lspd_pkg::cmd_t
module lspd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,
  input  lspd_pkg::stat_t     stat_i,
  output lspd_pkg::cmd_t      cmd_o
);

  localparam logic [3:0] StHunt  = 4'd0;
  localparam logic [3:0] StSync  = 4'd1;
  localparam logic [3:0] StKind  = 4'd2;
  localparam logic [3:0] StCount = 4'd3;
  localparam logic [3:0] StFaLo  = 4'd4;
  localparam logic [3:0] StFaHi  = 4'd5;
  localparam logic [3:0] StLaLo  = 4'd6;
  localparam logic [3:0] StLaHi  = 4'd7;
  localparam logic [3:0] StCsLo  = 4'd8;
  localparam logic [3:0] StCsHi  = 4'd9;
  localparam logic [3:0] StSLo   = 4'd10;
  localparam logic [3:0] StSHi   = 4'd11;
  localparam logic [3:0] StCalc  = 4'd12;
  localparam logic [3:0] StMod   = 4'd13;
  localparam logic [3:0] StEmit  = 4'd14;

  logic [3:0] state_q, state_d;
  logic       busy, acc;

  assign busy       = state_q inside {StCalc, StMod, StEmit};
  assign in_ready_o = !busy;
  assign acc        = in_valid_i && !busy;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StSync: begin
        if (acc) begin
          if (rx_byte_i == lspd_pkg::SyncByte1) state_d = StKind;
          else if (rx_byte_i != lspd_pkg::SyncByte0) state_d = StHunt;
        end
      end
      StKind: begin
        if (acc) begin
          cmd_o.ld_kind = 1'b1;
          state_d = StCount;
        end
      end
      StCount: begin
        if (acc) begin
          cmd_o.ld_count = 1'b1;
          state_d = StFaLo;
        end
      end
      StFaLo: begin
        if (acc) begin
          cmd_o.ld_lo = 1'b1;
          state_d = StFaHi;
        end
      end
      StFaHi: begin
        if (acc) begin
          cmd_o.ld_first = 1'b1;
          state_d = StLaLo;
        end
      end
      StLaLo: begin
        if (acc) begin
          cmd_o.ld_lo = 1'b1;
          state_d = StLaHi;
        end
      end
      StLaHi: begin
        if (acc) begin
          cmd_o.ld_span = 1'b1;
          state_d = StCsLo;
        end
      end
      StCsLo: begin
        if (acc) state_d = StCsHi;
      end
      StCsHi: begin
        if (acc) begin
          cmd_o.clr_ctr = 1'b1;
          state_d = stat_i.count_zero ? StHunt : StSLo;
        end
      end
      StSLo: begin
        if (acc) begin
          cmd_o.ld_lo = 1'b1;
          state_d = StSHi;
        end
      end
      StSHi: begin
        if (acc) begin
          cmd_o.start = 1'b1;
          state_d = StCalc;
        end
      end
      StCalc: begin
        if (stat_i.calc_done) begin
          cmd_o.mod_start = 1'b1;
          state_d = StMod;
        end
      end
      StMod: begin
        if (stat_i.mod_done) state_d = StEmit;
      end
      StEmit: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = stat_i.last ? StHunt : StSLo;
        end
      end
      default: begin
        // hunting for the first header byte
        if (acc) state_d = (rx_byte_i == lspd_pkg::SyncByte0) ? StSync : StHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StHunt;
    else         state_q <= state_d;
  end

endmodule

[rtl/lspd_datapath.sv]
// header holds, interpolation divider, cordic arctangent, modulo reduction
// and output register; depends on lspd_pkg and the assertion header
`include "lidar_scan_packet_decoder_assert.svh"
module lspd_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         rx_byte_i,
  input  lspd_pkg::cmd_t     cmd_i,
  output lspd_pkg::stat_t    stat_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [39:0]        out_data_o,
  output logic [7:0]         out_user_o,
  output logic               out_last_o
);

  logic [7:0]  kind_q, count_q, lo_q, ctr_q, idx_q;
  logic [14:0] first_q;
  logic [15:0] span_q, dist_q;
  logic        last_q;
  logic [15:0] word;
  logic [16:0] last_ang;

  logic [31:0] div_num_q;
  logic [7:0]  div_rem_q, divisor;
  logic [5:0]  div_cnt_q;
  logic        div_en_q;
  logic [8:0]  div_sh;
  logic        div_ge;

  logic signed [33:0] cx_q, cy_q, dx, dy;
  logic signed [21:0] cz_q, step_ang;
  logic [4:0]  cord_i_q;
  logic        rzero_q;

  logic [24:0] sum;
  logic [24:0] mod_rem_q;
  logic        mod_ge;

  logic        out_valid_q, out_last_q;
  logic [39:0] out_data_q;
  logic [7:0]  out_user_q;

  assign word     = {rx_byte_i, lo_q};
  assign last_ang = {2'b00, word[15:1]}
                  + (({1'b0, word[15:1]} < {1'b0, first_q}) ? 17'(lspd_pkg::FullTurn64) : 17'd0);
  assign divisor  = count_q - 8'd1;
  assign div_sh   = {div_rem_q, div_num_q[31]};
  assign div_ge   = div_sh >= {1'b0, divisor};

  assign dx       = cy_q >>> cord_i_q;
  assign dy       = cx_q >>> cord_i_q;
  assign step_ang = signed'(lspd_pkg::atan_lut(cord_i_q));

  // offset by a full turn so the sum never goes negative; it stays below six turns
  assign sum = 25'({first_q, 8'h00})
             + (div_en_q ? div_num_q[24:0] : 25'd0)
             + 25'(lspd_pkg::FullTurnU + lspd_pkg::RoundHalf)
             + (rzero_q ? 25'd0 : {{3{cz_q[21]}}, cz_q});
  assign mod_ge = mod_rem_q >= 25'(lspd_pkg::FullTurnU);

  // header holds and sample capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= '0;
      count_q <= '0;
      lo_q    <= '0;
      first_q <= '0;
      span_q  <= '0;
      ctr_q   <= '0;
      idx_q   <= '0;
      dist_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      if (cmd_i.ld_kind)  kind_q  <= rx_byte_i;
      if (cmd_i.ld_count) count_q <= rx_byte_i;
      if (cmd_i.ld_lo)    lo_q    <= rx_byte_i;
      if (cmd_i.ld_first) first_q <= word[15:1];
      if (cmd_i.ld_span)  span_q  <= last_ang[15:0] - {1'b0, first_q};
      if (cmd_i.clr_ctr)  ctr_q   <= '0;
      if (cmd_i.start) begin
        idx_q  <= ctr_q;
        dist_q <= word;
        last_q <= (ctr_q + 8'd1) == count_q;
        ctr_q  <= ctr_q + 8'd1;
      end
    end
  end

  // restoring divider for span*k*256/(n-1), quotient shifts into div_num_q
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_num_q <= '0;
      div_rem_q <= '0;
      div_cnt_q <= '0;
      div_en_q  <= 1'b0;
    end else if (cmd_i.start) begin
      div_num_q <= {({8'd0, span_q} * {16'd0, ctr_q}), 8'h00};
      div_rem_q <= '0;
      div_cnt_q <= 6'(lspd_pkg::DivSteps);
      div_en_q  <= count_q > 8'd1;
    end else if (div_cnt_q != 6'd0) begin
      div_rem_q <= div_ge ? 8'(div_sh - {1'b0, divisor}) : div_sh[7:0];
      div_num_q <= {div_num_q[30:0], div_ge};
      div_cnt_q <= div_cnt_q - 6'd1;
    end
  end

  // cordic vectoring, one rotation per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      cz_q     <= '0;
      cord_i_q <= 5'(lspd_pkg::CordicSteps);
      rzero_q  <= 1'b0;
    end else if (cmd_i.start) begin
      cx_q     <= signed'(34'(32'(word) * lspd_pkg::XGain));
      cy_q     <= signed'(34'(lspd_pkg::YBase)) - signed'(34'(32'(word) * lspd_pkg::YSlope));
      cz_q     <= '0;
      cord_i_q <= '0;
      rzero_q  <= word == 16'd0;
    end else if (cord_i_q != 5'(lspd_pkg::CordicSteps)) begin
      if (!cy_q[33]) begin
        cx_q <= cx_q + dx;
        cy_q <= cy_q - dy;
        cz_q <= cz_q + step_ang;
      end else begin
        cx_q <= cx_q - dx;
        cy_q <= cy_q + dy;
        cz_q <= cz_q - step_ang;
      end
      cord_i_q <= cord_i_q + 5'd1;
    end
  end

  // reduction modulo a full turn, one subtraction per cycle, at most five
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_rem_q <= '0;
    end else if (cmd_i.mod_start) begin
      mod_rem_q <= sum;
    end else if (mod_ge) begin
      mod_rem_q <= mod_rem_q - 25'(lspd_pkg::FullTurnU);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= {1'b0, mod_rem_q[22:8], dist_q, idx_q};
      out_user_q <= kind_q;
      out_last_q <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;
  assign out_last_o  = out_last_q;

  assign stat_o.count_zero = count_q == 8'd0;
  assign stat_o.calc_done  = (div_cnt_q == 6'd0) && (cord_i_q == 5'(lspd_pkg::CordicSteps));
  assign stat_o.mod_done   = !mod_ge;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  assign stat_o.last       = last_q;

  `LSPD_ASSERT(a_div_rem_bound, (div_en_q && div_cnt_q != 6'd0) |-> (div_rem_q < divisor))
  `LSPD_ASSERT(a_mod_rem_bound, cmd_i.emit |-> (mod_rem_q < 25'(lspd_pkg::FullTurnU)))
  `LSPD_ASSERT(a_emit_shows, cmd_i.emit |=> out_valid_q)
  `LSPD_ASSERT(a_ctr_bound, cmd_i.start |-> (ctr_q < count_q))
  `LSPD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_q)

endmodule

[rtl/lidar_scan_packet_decoder.sv]
// lidar scan packet decoder top level
// joins lspd_ctrl and lspd_datapath; depends on lspd_pkg
//
// usage: raw serial bytes enter on the s_axis channel, one byte per item.
// the block hunts for the header AA 55, reads kind, sample count, first and
// last angle and two checksum bytes, then one result item leaves on the
// m_axis channel for every two-byte distance sample.
// header and low sample bytes are taken one per cycle. the high byte of a
// sample starts the angle work and the input is held off while the
// bit-serial interpolation divider runs (the cordic arctangent runs its
// 17 steps alongside), the reduction starts, subtractions of a full turn
// bring the angle below one turn, the output stage is reached and the
// output register loads.
// a finished result waits in the output register; the next sample's bytes
// are still taken while it waits, and a new result loads only when the
// register is empty or being taken, so a stalled receiver holds off input.
// reset returns the parser to hunting for the header and clears the holds;
// tlast marks the final sample of a packet.
module lidar_scan_packet_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // sample_index[7:0], distance_quarter_mm[23:8], angle_sixtyfourths[38:24],
  // zero fill[39]
  output logic [39:0] m_axis_tdata_o,
  output logic [7:0]  m_axis_tuser_o,   // packet_kind
  output logic        m_axis_tlast_o    // last_sample
);

  lspd_pkg::cmd_t  cmd;
  lspd_pkg::stat_t stat;

  lspd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .rx_byte_i  (s_axis_tdata_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lspd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule
